// ===== hw/rtl/sfs_pkg.sv =====
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int TILE_W    = 16;
    localparam int FRAME_W   = 8;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // 8-bit sub tick plus 16-bit tick count, and frame plus step count, fit in 17 bits
    localparam int DIVD_W    = 17;
    localparam int DIVS_W    = 8;
    localparam int DIV_CNT_W = $clog2(DIVD_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_TILE    = 2'd0,
        CFG_FRAMES_TOTAL = 2'd1,
        CFG_TICKS_FRAME  = 2'd2,
        CFG_LOOPING      = 2'd3
    } t_cfg_idx;

    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DIVS_W-1:0] remainder;
    } t_div_rsp;

endpackage

// ===== hw/rtl/sfs_if.sv =====
`timescale 1ns / 1ps

interface sfs_in_if import sfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [TICK_W-1:0] tick_count;

    modport source (output valid, output mode, output tick_count, input ready);
    modport sink   (input valid, input mode, input tick_count, output ready);
endinterface

interface sfs_out_if import sfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              frame_moved;
    logic [TILE_W-1:0] tile_number;
    logic              done_flag;

    modport source (output valid, output frame_moved, output tile_number,
                    output done_flag, input ready);
    modport sink   (input valid, input frame_moved, input tile_number,
                    input done_flag, output ready);
endinterface

interface sfs_cfg_if import sfs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sprite_frame_sequencer_core.sv =====
`timescale 1ns / 1ps

// Sprite animation frame sequencer.
// i_cfg  : register writes (index 0 base tile, 1 frame count, 2 ticks per
//          frame, 3 loop enable). Always ready out of reset; write only
//          while no item is in flight.
// i_in   : items, mode 0 advances by tick_count, mode 1 restarts the
//          animation. Issue a restart after configuring.
// o_res  : one result per item: frame_moved, tile_number, done_flag.
// Flow: restart and no-op advances go from S_IDLE straight to S_WRITE, which
// loads the output register. An advance runs the shared divider (17
// iterations) once for the tick sum in S_DIV_TICK; a looping advance with a
// frame step runs it a second time for the frame wrap in S_DIV_WRAP. One item
// is in flight at a time; i_in.ready is high only while the sequencer is idle.
// Results sit in an output register; the next item is taken while a result
// waits. If o_res is stalled when the next result is ready, the sequencer
// holds it until the register frees.
// Reset (synchronous, active low) loads base tile 0, one frame, one tick per
// frame, looping on, and clears frame, sub tick and done flag.
module sprite_frame_sequencer_core
    import sfs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sfs_cfg_if.sink      i_cfg,
    sfs_in_if.sink       i_in,
    sfs_out_if.source    o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_TICK,
        S_DIV_WRAP,
        S_WRITE
    } t_state;

    t_state             r_state;

    logic [TILE_W-1:0]  r_base_tile;
    logic [FRAME_W-1:0] r_frames_total;
    logic [FRAME_W-1:0] r_ticks_frame;
    logic               r_looping;

    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] r_sub_tick;
    logic               r_ended;
    logic               r_moved;

    logic               r_out_valid;
    logic               r_out_moved;
    logic [TILE_W-1:0]  r_out_tile;
    logic               r_out_done;

    t_div_req           r_div_req;
    t_div_rsp           div_rsp;

    logic               in_acc;
    logic               cfg_acc;
    logic               out_free;
    logic [FRAME_W-1:0] frames_left;
    logic               no_op;

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign frames_left = (r_frame < r_frames_total) ? (r_frames_total - r_frame) : '0;
    assign no_op = (i_in.tick_count == '0) || r_ended ||
                   (r_frames_total == '0) || (r_ticks_frame == '0);

    sfs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_tile    <= '0;
            r_frames_total <= FRAME_W'(1);
            r_ticks_frame  <= FRAME_W'(1);
            r_looping      <= 1'b1;
        end else if (cfg_acc) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_BASE_TILE:    r_base_tile    <= i_cfg.data[TILE_W-1:0];
                CFG_FRAMES_TOTAL: r_frames_total <= i_cfg.data[FRAME_W-1:0];
                CFG_TICKS_FRAME:  r_ticks_frame  <= i_cfg.data[FRAME_W-1:0];
                CFG_LOOPING:      r_looping      <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_frame         <= '0;
            r_sub_tick      <= '0;
            r_ended         <= 1'b0;
            r_moved         <= 1'b0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            // S_WRITE reloads the register itself when it frees
            if (r_out_valid && o_res.ready && (r_state != S_WRITE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_moved <= 1'b0;
                        if (i_in.mode == MODE_RESTART) begin
                            r_frame    <= '0;
                            r_sub_tick <= '0;
                            r_ended    <= 1'b0;
                            r_state    <= S_WRITE;
                        end else if (no_op) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= {{(DIVD_W-FRAME_W){1'b0}}, r_sub_tick}
                                                + {{(DIVD_W-TICK_W){1'b0}}, i_in.tick_count};
                            r_div_req.divisor  <= r_ticks_frame;
                            r_state            <= S_DIV_TICK;
                        end
                    end
                end
                S_DIV_TICK: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quotient == '0) begin
                            r_sub_tick <= div_rsp.remainder;
                            r_state    <= S_WRITE;
                        end else if (r_looping) begin
                            r_sub_tick         <= div_rsp.remainder;
                            r_moved            <= 1'b1;
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= {{(DIVD_W-FRAME_W){1'b0}}, r_frame}
                                                + div_rsp.quotient;
                            r_div_req.divisor  <= r_frames_total;
                            r_state            <= S_DIV_WRAP;
                        end else begin
                            r_moved <= 1'b1;
                            // one-shot: clamp at the last frame once the steps run out
                            if (div_rsp.quotient >= {{(DIVD_W-FRAME_W){1'b0}}, frames_left}) begin
                                r_frame    <= r_frames_total - 1'b1;
                                r_sub_tick <= '0;
                                r_ended    <= 1'b1;
                            end else begin
                                r_frame    <= r_frame + div_rsp.quotient[FRAME_W-1:0];
                                r_sub_tick <= div_rsp.remainder;
                            end
                            r_state <= S_WRITE;
                        end
                    end else begin
                        r_div_req.start <= 1'b0;
                    end
                end
                S_DIV_WRAP: begin
                    if (div_rsp.done) begin
                        r_frame <= div_rsp.remainder;
                        r_state <= S_WRITE;
                    end else begin
                        r_div_req.start <= 1'b0;
                    end
                end
                S_WRITE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_moved <= r_moved;
                        r_out_tile  <= r_base_tile + {{(TILE_W-FRAME_W){1'b0}}, r_frame};
                        r_out_done  <= r_ended;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE) && i_rst_n;
    assign i_cfg.ready       = i_rst_n;
    assign o_res.valid       = r_out_valid;
    assign o_res.frame_moved = r_out_moved;
    assign o_res.tile_number = r_out_tile;
    assign o_res.done_flag   = r_out_done;

endmodule

// ===== hw/rtl/sfs_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sfs_divider
    import sfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVD_W-1:0]    r_q;
    logic [DIVS_W-1:0]    r_rem;
    logic [DIVS_W-1:0]    r_div;

    logic [DIVS_W:0]      shifted;
    logic                 fits;
    logic [DIVS_W:0]      diff;

    assign shifted = {r_rem, r_q[DIVD_W-1]};
    assign fits    = (shifted >= {1'b0, r_div});
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                // remainder stays below the divisor, so the low bits hold it
                r_rem <= fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
                r_q   <= {r_q[DIVD_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== hw/rtl/sfs_checker.sv =====
`timescale 1ns / 1ps

module sfs_checker
    import sfs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_moved,
    input logic [TILE_W-1:0] i_out_tile,
    input logic              i_out_done
);

    // one item in flight: the sequencer is busy right after taking one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while an item is in flight");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a result never appears on the edge right after the item that caused it is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("result shown too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_moved) && $stable(i_out_tile) &&
             $stable(i_out_done)))
        else $error("stalled result changed");

endmodule

bind sprite_frame_sequencer_core sfs_checker u_sfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_moved (o_res.frame_moved),
    .i_out_tile  (o_res.tile_number),
    .i_out_done  (o_res.done_flag)
);

// ===== sim/sprite_frame_sequencer_core_tb.sv =====
`timescale 1ns / 1ps

module sprite_frame_sequencer_core_tb;
    import sfs_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 50;

    typedef struct {
        logic              mode;
        logic [TICK_W-1:0] ticks;
    } t_anim_cmd;

    typedef struct {
        logic              moved;
        logic [TILE_W-1:0] tile;
        logic              done;
    } t_sprite_res;

    logic i_clk;
    logic i_rst_n;

    sfs_cfg_if cfg_if();
    sfs_in_if  in_if();
    sfs_out_if res_if();

    sprite_frame_sequencer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    // commands waiting for the driver, and results still owed by the block
    t_anim_cmd   cmd_q[$];
    t_sprite_res tile_exp_q[$];

    // shadow of the registers and the animation state
    logic [TILE_W-1:0]  cfg_base;
    logic [FRAME_W-1:0] cfg_frames;
    logic [FRAME_W-1:0] cfg_tpf;
    logic               cfg_loop;
    logic [FRAME_W-1:0] anim_frame;
    logic [FRAME_W-1:0] anim_sub;
    logic               anim_ended;

    logic        in_acc;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned rdy_left = 0;
    int          idle_cycles = 0;
    int          err_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sprite_res step_animation(t_anim_cmd c);
        t_sprite_res r;
        int unsigned sum, steps, left;
        r.moved = 1'b0;
        if (c.mode == MODE_RESTART) begin
            anim_frame = '0;
            anim_sub   = '0;
            anim_ended = 1'b0;
        end else if (c.ticks != 0 && !anim_ended && cfg_frames != 0 && cfg_tpf != 0) begin
            sum      = anim_sub + c.ticks;
            steps    = sum / cfg_tpf;
            anim_sub = FRAME_W'(sum % cfg_tpf);
            if (steps != 0) begin
                r.moved = 1'b1;
                if (cfg_loop) begin
                    anim_frame = FRAME_W'((anim_frame + steps) % cfg_frames);
                end else begin
                    // a frame left past a lowered count has no steps left
                    left = (anim_frame < cfg_frames) ? cfg_frames - anim_frame : 0;
                    if (steps >= left) begin
                        anim_frame = cfg_frames - 1'b1;
                        anim_sub   = '0;
                        anim_ended = 1'b1;
                    end else begin
                        anim_frame = FRAME_W'(anim_frame + steps);
                    end
                end
            end
        end
        r.tile = cfg_base + TILE_W'(anim_frame);
        r.done = anim_ended;
        return r;
    endfunction

    function automatic void queue_cmd(logic mode, logic [TICK_W-1:0] ticks);
        t_anim_cmd c;
        c.mode  = mode;
        c.ticks = ticks;
        cmd_q.push_back(c);
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || in_if.valid || tile_exp_q.size() != 0);
    endtask

    // item driver: bursts of random length, random gaps between them
    always @(negedge i_clk) begin
        t_anim_cmd c;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_acc) begin
            if (gap_left != 0) begin
                gap_left    <= gap_left - 1;
                in_if.valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                c = cmd_q.pop_front();
                in_if.valid      <= 1'b1;
                in_if.mode       <= c.mode;
                in_if.tick_count <= c.ticks;
                if (burst_left != 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result stalls: short on/off runs, now and then a long open stretch
    always @(negedge i_clk) begin
        if (rdy_left != 0) begin
            rdy_left <= rdy_left - 1;
        end else begin
            case ($urandom_range(0, 5))
                0: begin
                    res_if.ready <= 1'b1;
                    rdy_left     <= $urandom_range(40, 120);
                end
                1, 2: begin
                    res_if.ready <= 1'b0;
                    rdy_left     <= $urandom_range(0, 15);
                end
                default: begin
                    res_if.ready <= 1'b1;
                    rdy_left     <= $urandom_range(0, 8);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_sprite_res want;
        t_anim_cmd   c;
        if (!i_rst_n) begin
            cfg_base    = '0;
            cfg_frames  = 8'd1;
            cfg_tpf     = 8'd1;
            cfg_loop    = 1'b1;
            anim_frame  = '0;
            anim_sub    = '0;
            anim_ended  = 1'b0;
            in_acc      <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (t_cfg_idx'(cfg_if.index))
                    CFG_BASE_TILE:    cfg_base   = cfg_if.data[TILE_W-1:0];
                    CFG_FRAMES_TOTAL: cfg_frames = cfg_if.data[FRAME_W-1:0];
                    CFG_TICKS_FRAME:  cfg_tpf    = cfg_if.data[FRAME_W-1:0];
                    CFG_LOOPING:      cfg_loop   = cfg_if.data[0];
                    default: ;
                endcase
            end
            if (res_if.valid && res_if.ready) begin
                if (tile_exp_q.size() == 0) begin
                    $error("unexpected result: frame_moved %0b tile_number %0h done_flag %0b",
                           res_if.frame_moved, res_if.tile_number, res_if.done_flag);
                    err_count++;
                end else begin
                    want = tile_exp_q.pop_front();
                    if (res_if.frame_moved !== want.moved) begin
                        $error("frame_moved: expected %0b, got %0b",
                               want.moved, res_if.frame_moved);
                        err_count++;
                    end
                    if (res_if.tile_number !== want.tile) begin
                        $error("tile_number: expected %0h, got %0h",
                               want.tile, res_if.tile_number);
                        err_count++;
                    end
                    if (res_if.done_flag !== want.done) begin
                        $error("done_flag: expected %0b, got %0b",
                               want.done, res_if.done_flag);
                        err_count++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                c.mode  = in_if.mode;
                c.ticks = in_if.tick_count;
                tile_exp_q.push_back(step_animation(c));
            end
            in_acc <= in_if.valid && in_if.ready;
            if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("sprite_frame_sequencer_core_tb: errors");
        $finish;
    end

    initial begin
        int unsigned        gen_tpf, gen_frames;
        int                 ph, k;
        logic [TICK_W-1:0]  t;
        logic [CFG_DAT_W-1:0] val;

        i_rst_n          = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_BASE_TILE;
        cfg_if.data      = '0;
        in_if.valid      = 1'b0;
        in_if.mode       = MODE_ADVANCE;
        in_if.tick_count = '0;
        res_if.ready     = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero ticks, single-frame loop, restart
        queue_cmd(MODE_ADVANCE, 16'd0);
        queue_cmd(MODE_ADVANCE, 16'd1);
        queue_cmd(MODE_RESTART, 16'hFFFF);
        wait_drained();

        // tile number wraps past 16 bits; max tick count in loop mode
        write_reg(CFG_BASE_TILE, 16'hFFF0);
        write_reg(CFG_FRAMES_TOTAL, 16'd255);
        write_reg(CFG_TICKS_FRAME, 16'd1);
        write_reg(CFG_LOOPING, 16'd1);
        queue_cmd(MODE_RESTART, 16'd0);
        queue_cmd(MODE_ADVANCE, 16'd16);
        queue_cmd(MODE_ADVANCE, 16'hFFFF);
        wait_drained();

        // one-shot: partial frame, single step, clamp at end, advances once ended
        write_reg(CFG_BASE_TILE, 16'hFFFF);
        write_reg(CFG_FRAMES_TOTAL, 16'd4);
        write_reg(CFG_TICKS_FRAME, 16'd255);
        write_reg(CFG_LOOPING, 16'd0);
        queue_cmd(MODE_RESTART, 16'd0);
        queue_cmd(MODE_ADVANCE, 16'd254);
        queue_cmd(MODE_ADVANCE, 16'd1);
        queue_cmd(MODE_ADVANCE, 16'hFFFF);
        queue_cmd(MODE_ADVANCE, 16'd5);
        queue_cmd(MODE_ADVANCE, 16'd0);
        queue_cmd(MODE_RESTART, 16'd0);
        wait_drained();

        // frame past a lowered count and a stale sub tick, no restart between
        write_reg(CFG_BASE_TILE, 16'h0000);
        write_reg(CFG_FRAMES_TOTAL, 16'd255);
        write_reg(CFG_TICKS_FRAME, 16'd10);
        write_reg(CFG_LOOPING, 16'd1);
        queue_cmd(MODE_RESTART, 16'd0);
        queue_cmd(MODE_ADVANCE, 16'd2549);
        wait_drained();
        write_reg(CFG_FRAMES_TOTAL, 16'd3);
        write_reg(CFG_TICKS_FRAME, 16'd4);
        write_reg(CFG_LOOPING, 16'd0);
        queue_cmd(MODE_ADVANCE, 16'd1);
        wait_drained();
        write_reg(CFG_FRAMES_TOTAL, 16'd255);
        write_reg(CFG_TICKS_FRAME, 16'd1);
        write_reg(CFG_LOOPING, 16'd1);
        queue_cmd(MODE_RESTART, 16'd0);
        queue_cmd(MODE_ADVANCE, 16'd200);
        wait_drained();
        write_reg(CFG_FRAMES_TOTAL, 16'd5);
        queue_cmd(MODE_ADVANCE, 16'd3);
        wait_drained();

        gen_frames = 5;
        gen_tpf    = 1;
        for (ph = 0; ph < 10; ph++) begin
            wait_drained();
            // some phases keep old registers so stale state carries over
            if (ph == 0 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 3))
                    0: val = 16'hFFFF;
                    1: val = 16'h0000;
                    default: val = CFG_DAT_W'($urandom_range(0, 65535));
                endcase
                write_reg(CFG_BASE_TILE, val);
            end
            if (ph == 0 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 4))
                    0: gen_frames = 1;
                    1: gen_frames = 255;
                    2, 3: gen_frames = $urandom_range(2, 8);
                    default: gen_frames = $urandom_range(1, 255);
                endcase
                write_reg(CFG_FRAMES_TOTAL, CFG_DAT_W'(gen_frames));
            end
            if (ph == 0 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 4))
                    0: gen_tpf = 1;
                    1: gen_tpf = 255;
                    2, 3: gen_tpf = $urandom_range(1, 6);
                    default: gen_tpf = $urandom_range(1, 255);
                endcase
                write_reg(CFG_TICKS_FRAME, CFG_DAT_W'(gen_tpf));
            end
            if (ph == 0 || $urandom_range(0, 3) != 0)
                write_reg(CFG_LOOPING, CFG_DAT_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) != 0)
                queue_cmd(MODE_RESTART, TICK_W'($urandom_range(0, 65535)));

            for (k = 0; k < 40; k++) begin
                // hold off mid-phase until the block has caught up
                if (k == 20 && ph % 2 == 1)
                    wait_drained();
                if ($urandom_range(0, 7) == 0) begin
                    queue_cmd(MODE_RESTART, TICK_W'($urandom_range(0, 65535)));
                end else begin
                    case ($urandom_range(0, 9))
                        0: t = '0;
                        1: t = TICK_W'($urandom_range(0, 65535));
                        2: t = 16'hFFFF;
                        3, 4: t = TICK_W'($urandom_range(1, gen_tpf));
                        5: t = TICK_W'($urandom_range(1, gen_tpf * gen_frames + gen_tpf));
                        default: t = TICK_W'($urandom_range(1, gen_tpf * 4));
                    endcase
                    queue_cmd(MODE_ADVANCE, t);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tile_exp_q.size() != 0) begin
            $error("%0d results never arrived", tile_exp_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("sprite_frame_sequencer_core_tb: clean");
        else
            $display("sprite_frame_sequencer_core_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_if.sv
hw/rtl/sfs_divider.sv
hw/rtl/sprite_frame_sequencer_core.sv
hw/rtl/sfs_checker.sv
sim/sprite_frame_sequencer_core_tb.sv
